### src/billboard_yaw_toward_camera_top_macros.svh
// ----------------------------------------------------------------------------
// Billboard yaw assertion macros
// Shared check macros for the billboard yaw block.
// ----------------------------------------------------------------------------
`ifndef BILLBOARD_YAW_TOWARD_CAMERA_TOP_MACROS_SVH
`define BILLBOARD_YAW_TOWARD_CAMERA_TOP_MACROS_SVH

// check a consequence in the same cycle
`define BB_CHK_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// check a consequence in the next cycle
`define BB_CHK_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### src/bbyaw_pkg.sv
// ----------------------------------------------------------------------------
// Billboard yaw package
// Widths, angle constants, sequencer states and helper functions.
// ----------------------------------------------------------------------------
package bbyaw_pkg;

	localparam int CW = 34;
	localparam int MW = 34;
	localparam int AW = 68;
	localparam int STEPS = 30;
	localparam int SW = 5;

	localparam logic signed [CW-1:0] ANG_PI = 34'sd3373259426;
	localparam logic signed [CW-1:0] ANG_HALF_PI = 34'sd1686629713;
	localparam logic signed [CW-1:0] GAIN_INV = 34'sd652032874;
	localparam logic signed [MW-1:0] RECIP5 = 34'sd3435973837;
	localparam logic signed [AW-1:0] ROUND_HALF = 68'sd134217728;
	localparam logic signed [AW-1:0] LIMIT_POS = 68'sd1073741824;
	localparam logic signed [AW-1:0] LIMIT_NEG = -68'sd1073741824;

	typedef enum logic [3:0] {
		S_IDLE, S_PRE, S_DOT, S_NORM, S_VEC_GO, S_VEC_WAIT,
		S_DIV, S_ROT_GO, S_ROT_WAIT, S_TURN, S_OUT
	} state_t;

	typedef enum logic [2:0] {
		REG_CENTER_X, REG_CENTER_Y, REG_CENTER_Z, REG_HALF_W, REG_HALF_H
	} reg_idx_t;

	typedef struct packed {
		logic start;
		logic vect;
	} cordic_ctl_t;

	typedef struct packed {
		logic issue;
		logic neg;
		logic clr;
	} mac_ctl_t;

	function automatic logic signed [CW-1:0] atan_lut(input logic [SW-1:0] i);
		logic signed [CW-1:0] r;
		case (i)
			5'd0: r = 34'sd843314857;
			5'd1: r = 34'sd497837829;
			5'd2: r = 34'sd263043837;
			5'd3: r = 34'sd133525159;
			5'd4: r = 34'sd67021687;
			5'd5: r = 34'sd33543516;
			5'd6: r = 34'sd16775851;
			5'd7: r = 34'sd8388437;
			5'd8: r = 34'sd4194283;
			5'd9: r = 34'sd2097149;
			5'd10: r = 34'sd1048576;
			5'd11: r = 34'sd524288;
			5'd12: r = 34'sd262144;
			5'd13: r = 34'sd131072;
			5'd14: r = 34'sd65536;
			5'd15: r = 34'sd32768;
			5'd16: r = 34'sd16384;
			5'd17: r = 34'sd8192;
			5'd18: r = 34'sd4096;
			5'd19: r = 34'sd2048;
			5'd20: r = 34'sd1024;
			5'd21: r = 34'sd512;
			5'd22: r = 34'sd256;
			5'd23: r = 34'sd128;
			5'd24: r = 34'sd64;
			5'd25: r = 34'sd32;
			5'd26: r = 34'sd16;
			5'd27: r = 34'sd8;
			5'd28: r = 34'sd4;
			5'd29: r = 34'sd2;
			default: r = '0;
		endcase
		return r;
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [AW-1:0] v);
		logic signed [31:0] r;
		if (v > 68'sd2147483647)
			r = 32'sh7fffffff;
		else if (v < -68'sd2147483648)
			r = 32'sh80000000;
		else
			r = v[31:0];
		return r;
	endfunction

	function automatic logic big(input logic signed [AW-1:0] v);
		return (v >= LIMIT_POS) || (v <= LIMIT_NEG);
	endfunction

	// halve, truncating toward zero
	function automatic logic signed [AW-1:0] halve(input logic signed [AW-1:0] v);
		logic signed [AW-1:0] t;
		t = v + {{(AW-1){1'b0}}, v[AW-1]};
		return t >>> 1;
	endfunction

endpackage

### src/bbyaw_cordic.sv
// ----------------------------------------------------------------------------
// Billboard yaw CORDIC
// Iterative CORDIC, one micro-rotation per cycle, vectoring or rotation.
// ----------------------------------------------------------------------------
module bbyaw_cordic (
	input  logic                            clk,
	input  logic                            arst_n,
	input  bbyaw_pkg::cordic_ctl_t          ctl,
	input  logic signed [bbyaw_pkg::CW-1:0] x0,
	input  logic signed [bbyaw_pkg::CW-1:0] y0,
	input  logic signed [bbyaw_pkg::CW-1:0] z0,
	output logic signed [bbyaw_pkg::CW-1:0] x,
	output logic signed [bbyaw_pkg::CW-1:0] y,
	output logic signed [bbyaw_pkg::CW-1:0] z,
	output logic                            done
);
	import bbyaw_pkg::*;

	localparam logic [SW-1:0] LAST = SW'(STEPS - 1);

	logic signed [CW-1:0] x_q, y_q, z_q;
	logic signed [CW-1:0] xs, ys, at;
	logic [SW-1:0] i_q;
	logic busy_q, vect_q, done_q, dir;

	always_comb begin
		xs = x_q >>> i_q;
		ys = y_q >>> i_q;
		at = atan_lut(i_q);
		dir = vect_q ? (y_q <= 0) : (z_q >= 0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			vect_q <= 1'b0;
			i_q <= '0;
		end else begin
			done_q <= busy_q && (i_q == LAST);
			if (ctl.start) begin
				busy_q <= 1'b1;
				vect_q <= ctl.vect;
				i_q <= '0;
			end else if (busy_q) begin
				i_q <= i_q + 1'b1;
				if (i_q == LAST)
					busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			x_q <= x0;
			y_q <= y0;
			z_q <= z0;
		end else if (busy_q) begin
			if (dir) begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - at;
			end else begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + at;
			end
		end
	end

	assign x = x_q;
	assign y = y_q;
	assign z = z_q;
	assign done = done_q;

endmodule

### src/bbyaw_mac.sv
// ----------------------------------------------------------------------------
// Billboard yaw multiply-accumulate
// Registered product, then accumulate or clear-and-load.
// ----------------------------------------------------------------------------
module bbyaw_mac (
	input  logic                            clk,
	input  logic                            arst_n,
	input  bbyaw_pkg::mac_ctl_t             ctl,
	input  logic signed [bbyaw_pkg::MW-1:0] opa,
	input  logic signed [bbyaw_pkg::MW-1:0] opb,
	output logic signed [bbyaw_pkg::AW-1:0] acc
);
	import bbyaw_pkg::*;

	logic signed [AW-1:0] prod_s1, acc_q;
	mac_ctl_t ctl_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			ctl_s1 <= '0;
		else
			ctl_s1 <= ctl;
	end

	always_ff @(posedge clk) begin
		if (ctl.issue)
			prod_s1 <= opa * opb;
		if (ctl_s1.issue)
			acc_q <= (ctl_s1.clr ? '0 : acc_q) + (ctl_s1.neg ? -prod_s1 : prod_s1);
	end

	assign acc = acc_q;

endmodule

### src/billboard_yaw_toward_camera_top.sv
// ----------------------------------------------------------------------------
// Billboard yaw toward camera
// Keeps a vertical quad and turns it about the vertical axis toward the camera.
// ----------------------------------------------------------------------------
//  channel  | handshake                  | payload
//  ---------+----------------------------+-----------------------------------
//  in       | in_valid / in_ready        | action, forward_x, forward_z
//  out      | out_valid / out_ready      | corner0..3 x/z, bottom_y, top_y,
//           |                            | status
//  cfg      | psel/penable/pwrite/pready | paddr, pwdata, prdata
//
//  A build or a flagged/degenerate update reaches the result in the next cycle.
//  A full update runs operand scaling, 4 MAC ops, up to 33 halving steps,
//  one or two 30-step CORDIC passes, a divide by five and 16 MAC ops,
//  all on one MAC and one CORDIC unit.
//  in_ready is high only while idle; the result holds until out_ready.
//  Reset clears corners to zero and registers to their defaults.
// ----------------------------------------------------------------------------
module billboard_yaw_toward_camera_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               action,
	input  logic signed [31:0] forward_x,
	input  logic signed [31:0] forward_z,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] corner0_x,
	output logic signed [31:0] corner0_z,
	output logic signed [31:0] corner1_x,
	output logic signed [31:0] corner1_z,
	output logic signed [31:0] corner2_x,
	output logic signed [31:0] corner2_z,
	output logic signed [31:0] corner3_x,
	output logic signed [31:0] corner3_z,
	output logic signed [31:0] bottom_y,
	output logic signed [31:0] top_y,
	output logic               status,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [4:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);
	import bbyaw_pkg::*;

	`include "billboard_yaw_toward_camera_top_macros.svh"

	state_t state_q, state_d;

	logic signed [31:0] cx_q, cy_q, cz_q;
	logic [30:0] hw_q, hh_q;
	logic signed [31:0] cnx_q [4];
	logic signed [31:0] cnz_q [4];
	logic signed [31:0] yb_q, yt_q;
	logic status_q;

	logic signed [32:0] a_q, b_q, fx_q, fz_q;
	logic signed [AW-1:0] dot_q, crs_q;
	logic signed [CW-1:0] phi_q;
	logic signed [MW-1:0] c_q, s_q;
	logic signed [31:0] nx_q;
	logic [5:0] m_q;

	logic signed [AW-1:0] cx_w, cy_w, cz_w, hw_w, hh_w;
	logic signed [32:0] dif_a, dif_b, dif_y;
	logic degen, zero_f, acc_in, cfg_wr;
	logic pre_ab, pre_f, pre_dc;
	logic signed [AW-1:0] ha_w, hb_w, hfx_w, hfz_w;
	logic signed [31:0] rnd_x, rnd_z;
	logic [3:0] d_idx;
	logic [1:0] ki, kd;
	logic signed [32:0] dx_w, dz_w;
	logic [31:0] quo;
	logic signed [CW-1:0] phi_mag;

	cordic_ctl_t cordic_ctl;
	logic signed [CW-1:0] cx0, cy0, cz0, cor_x, cor_y, cor_z;
	logic cordic_done;

	mac_ctl_t mac_ctl;
	logic signed [MW-1:0] opa, opb;
	logic signed [AW-1:0] acc;

	bbyaw_cordic u_cordic (
		.clk(clk), .arst_n(arst_n), .ctl(cordic_ctl),
		.x0(cx0), .y0(cy0), .z0(cz0),
		.x(cor_x), .y(cor_y), .z(cor_z), .done(cordic_done)
	);

	bbyaw_mac u_mac (
		.clk(clk), .arst_n(arst_n), .ctl(mac_ctl),
		.opa(opa), .opb(opb), .acc(acc)
	);

	// configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_comb begin
		case (paddr[4:2])
			REG_CENTER_X: prdata = cx_q;
			REG_CENTER_Y: prdata = cy_q;
			REG_CENTER_Z: prdata = cz_q;
			REG_HALF_W: prdata = {1'b0, hw_q};
			REG_HALF_H: prdata = {1'b0, hh_q};
			default: prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cx_q <= '0;
			cy_q <= '0;
			cz_q <= '0;
			hw_q <= 31'd65536;
			hh_q <= 31'd65536;
		end else if (cfg_wr) begin
			case (paddr[4:2])
				REG_CENTER_X: cx_q <= pwdata;
				REG_CENTER_Y: cy_q <= pwdata;
				REG_CENTER_Z: cz_q <= pwdata;
				REG_HALF_W: hw_q <= pwdata[30:0];
				REG_HALF_H: hh_q <= pwdata[30:0];
				default: ;
			endcase
		end
	end

	// shared combinational terms
	always_comb begin
		cx_w = {{(AW-32){cx_q[31]}}, cx_q};
		cy_w = {{(AW-32){cy_q[31]}}, cy_q};
		cz_w = {{(AW-32){cz_q[31]}}, cz_q};
		hw_w = {{(AW-31){1'b0}}, hw_q};
		hh_w = {{(AW-31){1'b0}}, hh_q};
		dif_a = {cnx_q[1][31], cnx_q[1]} - {cnx_q[0][31], cnx_q[0]};
		dif_b = {cnz_q[1][31], cnz_q[1]} - {cnz_q[0][31], cnz_q[0]};
		dif_y = {yt_q[31], yt_q} - {yb_q[31], yb_q};
		degen = (dif_y <= 0) || (dif_a == 0 && dif_b == 0);
		zero_f = (forward_x == 0) && (forward_z == 0);
		acc_in = in_valid && in_ready;
		ha_w = halve(AW'(a_q));
		hb_w = halve(AW'(b_q));
		hfx_w = halve(AW'(fx_q));
		hfz_w = halve(AW'(fz_q));
		pre_ab = big(AW'(a_q)) || big(AW'(b_q));
		pre_f = big(AW'(fx_q)) || big(AW'(fz_q));
		pre_dc = big(dot_q) || big(crs_q);
		rnd_x = sat32(((acc + ROUND_HALF) >>> 28) + cx_w);
		rnd_z = sat32(((acc + ROUND_HALF) >>> 28) + cz_w);
		d_idx = 4'(m_q[5:1] - 5'd1);
		ki = m_q[4:3];
		kd = d_idx[3:2];
		dx_w = {cnx_q[ki][31], cnx_q[ki]} - {cx_q[31], cx_q};
		dz_w = {cnz_q[ki][31], cnz_q[ki]} - {cz_q[31], cz_q};
		quo = acc[65:34];
		phi_mag = phi_q[CW-1] ? -phi_q : phi_q;
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (acc_in) begin
					if (!action || zero_f || degen)
						state_d = S_OUT;
					else
						state_d = S_PRE;
				end
			end
			S_PRE: begin
				if (!pre_ab && !pre_f)
					state_d = S_DOT;
			end
			S_DOT: begin
				if (m_q == 6'd8)
					state_d = S_NORM;
			end
			S_NORM: begin
				if (!pre_dc)
					state_d = (crs_q == 0) ? S_DIV : S_VEC_GO;
			end
			S_VEC_GO: state_d = S_VEC_WAIT;
			S_VEC_WAIT: begin
				if (cordic_done)
					state_d = S_DIV;
			end
			S_DIV: begin
				if (m_q == 6'd2)
					state_d = S_ROT_GO;
			end
			S_ROT_GO: state_d = S_ROT_WAIT;
			S_ROT_WAIT: begin
				if (cordic_done)
					state_d = S_TURN;
			end
			S_TURN: begin
				if (m_q == 6'd32)
					state_d = S_OUT;
			end
			S_OUT: begin
				if (out_ready)
					state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// outputs and unit controls
	always_comb begin
		in_ready = 1'b0;
		out_valid = 1'b0;
		cordic_ctl = '0;
		cx0 = '0;
		cy0 = '0;
		cz0 = '0;
		mac_ctl = '0;
		opa = '0;
		opb = '0;
		case (state_q)
			S_IDLE: in_ready = 1'b1;
			S_OUT: out_valid = 1'b1;
			S_DOT: begin
				mac_ctl.issue = !m_q[0] && !m_q[3];
				case (m_q[2:1])
					2'd0: begin
						opa = MW'(b_q);
						opb = MW'(fx_q);
						mac_ctl.clr = 1'b1;
					end
					2'd1: begin
						opa = MW'(a_q);
						opb = MW'(fz_q);
						mac_ctl.neg = 1'b1;
					end
					2'd2: begin
						opa = MW'(a_q);
						opb = MW'(fx_q);
						mac_ctl.clr = 1'b1;
					end
					default: begin
						opa = MW'(b_q);
						opb = MW'(fz_q);
					end
				endcase
			end
			S_VEC_GO: begin
				cordic_ctl.start = 1'b1;
				cordic_ctl.vect = 1'b1;
				if (dot_q < 0) begin
					if (crs_q > 0) begin
						cx0 = crs_q[CW-1:0];
						cy0 = -dot_q[CW-1:0];
						cz0 = ANG_HALF_PI;
					end else begin
						cx0 = -crs_q[CW-1:0];
						cy0 = dot_q[CW-1:0];
						cz0 = -ANG_HALF_PI;
					end
				end else begin
					cx0 = dot_q[CW-1:0];
					cy0 = crs_q[CW-1:0];
				end
			end
			S_DIV: begin
				mac_ctl.issue = (m_q == 6'd0);
				mac_ctl.clr = 1'b1;
				opa = phi_mag;
				opb = RECIP5;
			end
			S_ROT_GO: begin
				cordic_ctl.start = 1'b1;
				cx0 = GAIN_INV;
				cz0 = phi_q;
			end
			S_TURN: begin
				mac_ctl.issue = !m_q[0] && !m_q[5];
				case (m_q[2:1])
					2'd0: begin
						opa = MW'(dx_w);
						opb = c_q;
						mac_ctl.clr = 1'b1;
					end
					2'd1: begin
						opa = MW'(dz_w);
						opb = s_q;
					end
					2'd2: begin
						opa = MW'(dz_w);
						opb = c_q;
						mac_ctl.clr = 1'b1;
					end
					default: begin
						opa = MW'(dx_w);
						opb = s_q;
						mac_ctl.neg = 1'b1;
					end
				endcase
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

	// sequencer counter and corner state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_q <= '0;
			status_q <= 1'b0;
			yb_q <= '0;
			yt_q <= '0;
			for (int k = 0; k < 4; k++) begin
				cnx_q[k] <= '0;
				cnz_q[k] <= '0;
			end
		end else begin
			if (state_d != state_q)
				m_q <= '0;
			else if (state_q == S_DOT || state_q == S_DIV || state_q == S_TURN)
				m_q <= m_q + 1'b1;
			if (acc_in) begin
				status_q <= action && zero_f;
				if (!action) begin
					cnx_q[0] <= sat32(cx_w - hw_w);
					cnx_q[2] <= sat32(cx_w - hw_w);
					cnx_q[1] <= sat32(cx_w + hw_w);
					cnx_q[3] <= sat32(cx_w + hw_w);
					yb_q <= sat32(cy_w - hh_w);
					yt_q <= sat32(cy_w + hh_w);
					for (int k = 0; k < 4; k++)
						cnz_q[k] <= cz_q;
				end
			end
			if (state_q == S_TURN && !m_q[0] && m_q != 6'd0 && d_idx[1:0] == 2'd3) begin
				cnx_q[kd] <= nx_q;
				cnz_q[kd] <= rnd_z;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				a_q <= dif_a;
				b_q <= dif_b;
				fx_q <= {forward_x[31], forward_x};
				fz_q <= {forward_z[31], forward_z};
			end
			S_PRE: begin
				if (pre_ab) begin
					a_q <= ha_w[32:0];
					b_q <= hb_w[32:0];
				end
				if (pre_f) begin
					fx_q <= hfx_w[32:0];
					fz_q <= hfz_w[32:0];
				end
			end
			S_DOT: begin
				if (m_q == 6'd4)
					dot_q <= acc;
				if (m_q == 6'd8)
					crs_q <= acc;
			end
			S_NORM: begin
				if (pre_dc) begin
					dot_q <= halve(dot_q);
					crs_q <= halve(crs_q);
				end else
					phi_q <= (dot_q < 0) ? ANG_PI : '0;
			end
			S_VEC_WAIT: begin
				if (cordic_done)
					phi_q <= -cor_z;
			end
			S_DIV: begin
				if (m_q == 6'd2)
					phi_q <= phi_q[CW-1] ? -CW'({2'b00, quo}) : CW'({2'b00, quo});
			end
			S_ROT_WAIT: begin
				if (cordic_done) begin
					c_q <= cor_x >>> 2;
					s_q <= cor_y >>> 2;
				end
			end
			S_TURN: begin
				if (!m_q[0] && m_q != 6'd0 && d_idx[1:0] == 2'd1)
					nx_q <= rnd_x;
			end
			default: ;
		endcase
	end

	assign corner0_x = cnx_q[0];
	assign corner0_z = cnz_q[0];
	assign corner1_x = cnx_q[1];
	assign corner1_z = cnz_q[1];
	assign corner2_x = cnx_q[2];
	assign corner2_z = cnz_q[2];
	assign corner3_x = cnx_q[3];
	assign corner3_z = cnz_q[3];
	assign bottom_y = yb_q;
	assign top_y = yt_q;
	assign status = status_q;

	`BB_CHK_NEXT(a_busy_after_in, in_valid && in_ready, !in_ready, "input taken while busy")
	`BB_CHK_NOW(a_no_overlap, out_valid, !in_ready, "result and input open together")
	`BB_CHK_NOW(a_cordic_wait, cordic_done, state_q == S_VEC_WAIT || state_q == S_ROT_WAIT, "cordic done outside wait")
	`BB_CHK_NEXT(a_release, out_valid && out_ready, in_ready, "no return to idle after result")

endmodule

### test/tb_billboard_yaw_toward_camera_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Billboard yaw toward camera testbench
// Builds quads from several register settings and turns them toward random
// and edge-case camera vectors. A behavioral predictor of the corner
// arithmetic runs beside the block, and every result is checked in order.
// ----------------------------------------------------------------------------
module tb_billboard_yaw_toward_camera_top;
	import bbyaw_pkg::*;

	localparam longint TURN_PI = 64'sd3373259426;
	localparam longint TURN_HALF_PI = 64'sd1686629713;
	localparam longint UNIT_GAIN = 64'sd652032874;
	localparam longint SCALE_LIMIT = 64'sd1073741824;
	localparam bit ACT_BUILD = 1'b0;
	localparam bit ACT_TURN = 1'b1;

	typedef struct {
		logic signed [31:0] cx[4];
		logic signed [31:0] cz[4];
		logic signed [31:0] ybot;
		logic signed [31:0] ytop;
		logic               flag;
	} quad_result_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic               action = 1'b0;
	logic signed [31:0] forward_x = '0;
	logic signed [31:0] forward_z = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic signed [31:0] corner0_x, corner0_z, corner1_x, corner1_z;
	logic signed [31:0] corner2_x, corner2_z, corner3_x, corner3_z;
	logic signed [31:0] bottom_y, top_y;
	logic               status;
	logic               psel = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite = 1'b0;
	logic [4:0]         paddr = '0;
	logic [31:0]        pwdata = '0;
	logic [31:0]        prdata;
	logic               pready;

	longint reg_cx, reg_cy, reg_cz, reg_hw, reg_hh;
	logic signed [31:0] quad_xyz[12];
	quad_result_t expected_quads[$];
	int mismatches = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;

	longint atan_steps[30] = '{
		843314857, 497837829, 263043837, 133525159, 67021687,
		33543516, 16775851, 8388437, 4194283, 2097149,
		1048576, 524288, 262144, 131072, 65536,
		32768, 16384, 8192, 4096, 2048,
		1024, 512, 256, 128, 64, 32, 16, 8, 4, 2};

	billboard_yaw_toward_camera_top DUT (.*);

	always #2 clk = ~clk;

	initial begin
		#20000000;
		$display("Regression FAIL");
		$finish;
	end

	function automatic longint clip32(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	function automatic longint fshr(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint absv(longint v);
		return v < 0 ? -v : v;
	endfunction

	task automatic shrink_pair(inout longint p, inout longint q);
		while (absv(p) >= SCALE_LIMIT || absv(q) >= SCALE_LIMIT) begin
			p = p / 2;
			q = q / 2;
		end
	endtask

	function automatic longint angle_of(longint y, longint x);
		longint z, t, xs, ys;
		z = 0;
		if (x < 0) begin
			if (y > 0) begin
				t = x; x = y; y = -t; z = TURN_HALF_PI;
			end else begin
				t = x; x = -y; y = t; z = -TURN_HALF_PI;
			end
		end
		for (int i = 0; i < 30; i++) begin
			xs = fshr(x, i);
			ys = fshr(y, i);
			if (y > 0) begin
				x += ys; y -= xs; z += atan_steps[i];
			end else begin
				x -= ys; y += xs; z -= atan_steps[i];
			end
		end
		return z;
	endfunction

	task automatic rotor_of(longint r, output longint c, output longint s);
		longint x, y, xs, ys;
		x = UNIT_GAIN;
		y = 0;
		for (int i = 0; i < 30; i++) begin
			xs = fshr(x, i);
			ys = fshr(y, i);
			if (r >= 0) begin
				x -= ys; y += xs; r -= atan_steps[i];
			end else begin
				x += ys; y -= xs; r += atan_steps[i];
			end
		end
		c = x;
		s = y;
	endtask

	task automatic predict_quad(bit act, longint fx, longint fz);
		quad_result_t q;
		longint a, b, dy, dp, cp, phi, c, s, dx, dz;
		q.flag = 1'b0;
		if (act == ACT_BUILD) begin
			for (int k = 0; k < 4; k++) begin
				quad_xyz[3*k] = 32'(clip32((k & 1) ? reg_cx + reg_hw : reg_cx - reg_hw));
				quad_xyz[3*k+1] = 32'(clip32((k & 2) ? reg_cy + reg_hh : reg_cy - reg_hh));
				quad_xyz[3*k+2] = 32'(reg_cz);
			end
		end else if (fx == 0 && fz == 0) begin
			q.flag = 1'b1;
		end else begin
			a = longint'(quad_xyz[3]) - quad_xyz[0];
			b = longint'(quad_xyz[5]) - quad_xyz[2];
			dy = longint'(quad_xyz[7]) - quad_xyz[1];
			if (dy > 0 && !(a == 0 && b == 0)) begin
				shrink_pair(a, b);
				shrink_pair(fx, fz);
				dp = b * fx - a * fz;
				cp = a * fx + b * fz;
				shrink_pair(dp, cp);
				if (cp == 0) phi = (dp < 0) ? TURN_PI : 0;
				else phi = -angle_of(cp, dp);
				rotor_of(phi / 5, c, s);
				c = fshr(c, 2);
				s = fshr(s, 2);
				for (int k = 0; k < 4; k++) begin
					dx = longint'(quad_xyz[3*k]) - reg_cx;
					dz = longint'(quad_xyz[3*k+2]) - reg_cz;
					quad_xyz[3*k] =
						32'(clip32(fshr(dx*c + dz*s + (64'sd1 <<< 27), 28) + reg_cx));
					quad_xyz[3*k+2] =
						32'(clip32(fshr(dz*c - dx*s + (64'sd1 <<< 27), 28) + reg_cz));
				end
			end
		end
		for (int k = 0; k < 4; k++) begin
			q.cx[k] = quad_xyz[3*k];
			q.cz[k] = quad_xyz[3*k+2];
		end
		q.ybot = quad_xyz[1];
		q.ytop = quad_xyz[7];
		expected_quads.push_back(q);
	endtask

	task automatic write_reg(reg_idx_t idx, logic [31:0] val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= 5'(idx) << 2;
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_CENTER_X: reg_cx = longint'(signed'(val));
			REG_CENTER_Y: reg_cy = longint'(signed'(val));
			REG_CENTER_Z: reg_cz = longint'(signed'(val));
			REG_HALF_W: reg_hw = longint'(val[30:0]);
			REG_HALF_H: reg_hh = longint'(val[30:0]);
			default: ;
		endcase
	endtask

	task automatic set_quad(logic [31:0] x, logic [31:0] y, logic [31:0] z,
			logic [31:0] w, logic [31:0] h);
		wait (expected_quads.size() == 0);
		repeat (4) @(posedge clk);
		write_reg(REG_CENTER_X, x);
		write_reg(REG_CENTER_Y, y);
		write_reg(REG_CENTER_Z, z);
		write_reg(REG_HALF_W, w);
		write_reg(REG_HALF_H, h);
	endtask

	task automatic send_item(bit act, logic signed [31:0] fx, logic signed [31:0] fz);
		@(posedge clk);
		while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
			@(posedge clk);
		in_valid <= 1'b1;
		action <= act;
		forward_x <= fx;
		forward_z <= fz;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		predict_quad(act, longint'(fx), longint'(fz));
		in_valid <= 1'b0;
	endtask

	function automatic logic signed [31:0] rand_vec();
		case ($urandom_range(4))
			0: return $urandom;
			1: return signed'(32'($urandom_range(131071))) - 65536;
			2: return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
			default: return signed'($urandom) >>> $urandom_range(20);
		endcase
	endfunction

	always @(posedge clk) begin
		if (recv_stall_pct > 0)
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		else
			out_ready <= 1'b1;
	end

	always @(posedge clk) begin
		quad_result_t q;
		logic signed [31:0] got[11];
		logic signed [31:0] want[11];
		if (arst_n && out_valid && out_ready) begin
			if (expected_quads.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected transaction at %0t", $realtime);
			end else begin
				q = expected_quads.pop_front();
				got = '{corner0_x, corner0_z, corner1_x, corner1_z, corner2_x,
					corner2_z, corner3_x, corner3_z, bottom_y, top_y, 32'(status)};
				want = '{q.cx[0], q.cz[0], q.cx[1], q.cz[1], q.cx[2], q.cz[2],
					q.cx[3], q.cz[3], q.ybot, q.ytop, 32'(q.flag)};
				for (int i = 0; i < 11; i++) begin
					if (got[i] !== want[i]) begin
						mismatches++;
						if (mismatches <= 10)
							$display("field %0d mismatch at %0t: expected %h actual %h",
								i, $realtime, want[i], got[i]);
					end
				end
			end
		end
	end

	task automatic test_directed();
		send_item(ACT_TURN, 32'sd65536, 32'sd0);
		send_item(ACT_BUILD, 32'sh7fffffff, 32'sh80000000);
		send_item(ACT_TURN, 32'sd0, 32'sd0);
		send_item(ACT_TURN, 32'sd0, 32'sd65536);
		send_item(ACT_TURN, 32'sd0, -32'sd65536);
		send_item(ACT_TURN, 32'sd65536, 32'sd0);
		send_item(ACT_TURN, -32'sd65536, 32'sd0);
		send_item(ACT_TURN, 32'sh7fffffff, 32'sh7fffffff);
		send_item(ACT_TURN, 32'sh80000000, 32'sh80000000);
		send_item(ACT_TURN, 32'sh80000000, 32'sh7fffffff);
		send_item(ACT_TURN, 32'sd1, -32'sd1);
		send_item(ACT_TURN, -32'sd1, 32'sd0);
		set_quad(32'h7fff0000, 32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff);
		send_item(ACT_BUILD, 0, 0);
		send_item(ACT_TURN, 32'sd12345, -32'sd99999);
		set_quad(0, 0, 0, 0, 32'd65536);
		send_item(ACT_BUILD, 0, 0);
		send_item(ACT_TURN, 32'sd65536, 32'sd65536);
		set_quad(0, 0, 0, 32'd65536, 0);
		send_item(ACT_BUILD, 0, 0);
		send_item(ACT_TURN, 32'sd65536, 32'sd65536);
	endtask

	task automatic test_random(int count);
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(15) == 0) send_item(ACT_BUILD, $urandom, $urandom);
			else if ($urandom_range(40) == 0) send_item(ACT_TURN, 0, 0);
			else send_item(ACT_TURN, rand_vec(), rand_vec());
		end
	endtask

	task automatic test_settings();
		set_quad($urandom, $urandom, $urandom, $urandom, $urandom);
		send_item(ACT_BUILD, 0, 0);
		test_random(200);
		set_quad(32'(signed'($urandom_range(2000000)) - 1000000) <<< 4,
			$urandom_range(65536), 32'hfff00000, $urandom_range(1 << 20),
			$urandom_range(1 << 20));
		send_item(ACT_BUILD, 0, 0);
		test_random(200);
	endtask

	initial begin
		reg_cx = 0;
		reg_cy = 0;
		reg_cz = 0;
		reg_hw = 65536;
		reg_hh = 65536;
		foreach (quad_xyz[i]) quad_xyz[i] = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		set_quad(32'h00030000, 32'hfffe0000, 32'h00050000, 32'h00020000, 32'h00010000);
		send_item(ACT_BUILD, 0, 0);
		test_random(400);
		send_idle_pct = 78;
		test_settings();
		send_idle_pct = 0;
		recv_stall_pct = 78;
		test_settings();
		send_idle_pct = 24;
		recv_stall_pct = 24;
		test_settings();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		set_quad(32'h80000000, 32'h7fffffff, 32'h7fffffff, 0, 0);
		send_item(ACT_BUILD, 0, 0);
		test_random(20);
		wait (expected_quads.size() == 0);
		repeat (300) @(posedge clk);
		if (mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end
endmodule
